// ===== src/jeu_pkg.sv =====
`default_nettype none

package jeu_pkg;

  localparam int HELD_DEPTH = 3;
  localparam int MAX_UNITS  = 4;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  localparam logic [1:0] TAG_CONT   = 2'b10;
  localparam logic [2:0] TAG_LEAD2  = 3'b110;
  localparam logic [3:0] TAG_LEAD3  = 4'b1110;
  localparam logic [4:0] TAG_LEAD4  = 5'b11110;

  // character positions inside one escape sequence
  localparam logic [2:0] POS_BSLASH = 3'd0;
  localparam logic [2:0] POS_U      = 3'd1;
  localparam logic [2:0] POS_ZERO0  = 3'd2;
  localparam logic [2:0] POS_ZERO1  = 3'd3;
  localparam logic [2:0] POS_HI     = 3'd4;
  localparam logic [2:0] POS_LO     = 3'd5;

  typedef logic [7:0] byte_t;

  // one output unit: a byte sent as is, or a byte sent as a six-char escape
  typedef struct packed {
    logic  esc;
    byte_t value;
  } unit_t;

  typedef struct packed {
    unit_t [MAX_UNITS-1:0] units;
    logic  [2:0]           count;
    logic                  last;
  } plan_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  function automatic byte_t hex_digit(input logic [3:0] d);
    byte_t r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'd0, d};
    end else begin
      r = CH_UPPER_A + {4'd0, d - 4'd10};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/jeu_if.sv =====
`default_nettype none

interface jeu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface jeu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input string_end,
                output ready);
endinterface

`default_nettype wire

// ===== src/jeu_plan.sv =====
`default_nettype none

module jeu_plan (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  jeu_pkg::byte_t  in_byte,
  input  logic            in_last,
  output jeu_pkg::plan_t  plan
);
  import jeu_pkg::*;

  byte_t      held [HELD_DEPTH];
  logic [1:0] held_count;
  logic [1:0] need;

  byte_t      held_next [HELD_DEPTH];
  logic [1:0] held_count_next;
  logic [1:0] need_next;

  function automatic plan_t put(input plan_t p, input logic esc, input byte_t v);
    plan_t r;
    r = p;
    r.units[p.count[1:0]].esc   = esc;
    r.units[p.count[1:0]].value = v;
    r.count = p.count + 3'd1;
    return r;
  endfunction

  always_comb begin
    plan_t      p;
    logic       fresh;
    logic [1:0] lead_need;
    logic       esc_now;
    logic       raw_now;
    p               = '0;
    p.last          = in_last;
    fresh           = 1'b0;
    lead_need       = 2'd0;
    esc_now         = 1'b0;
    raw_now         = 1'b0;
    held_next       = held;
    held_count_next = held_count;
    need_next       = need;

    if (held_count != 2'd0) begin
      if (in_byte[7:6] == TAG_CONT) begin
        if (need <= 2'd1) begin
          for (int i = 0; i < HELD_DEPTH; i++) begin
            if (2'(i) < held_count) p = put(p, 1'b0, held[i]);
          end
          p = put(p, 1'b0, in_byte);
          held_count_next = 2'd0;
          need_next       = 2'd0;
        end else if (held_count < 2'(HELD_DEPTH)) begin
          held_next[held_count] = in_byte;
          held_count_next       = held_count + 2'd1;
          need_next             = need - 2'd1;
        end else begin
          for (int i = 0; i < HELD_DEPTH; i++) begin
            if (2'(i) < held_count) p = put(p, 1'b1, held[i]);
          end
          p = put(p, 1'b1, in_byte);
          held_count_next = 2'd0;
          need_next       = 2'd0;
        end
      end else begin
        // broken sequence
        for (int i = 0; i < HELD_DEPTH; i++) begin
          if (2'(i) < held_count) p = put(p, 1'b1, held[i]);
        end
        held_count_next = 2'd0;
        need_next       = 2'd0;
        fresh           = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      priority if (in_byte < CTRL_LIMIT || in_byte == CH_BSLASH || in_byte == CH_QUOTE) begin
        esc_now = 1'b1;
      end else if (!in_byte[7]) begin
        raw_now = 1'b1;
      end else if (in_byte[7:6] == TAG_CONT) begin
        esc_now = 1'b1;
      end else if (in_byte[7:5] == TAG_LEAD2) begin
        lead_need = 2'd1;
      end else if (in_byte[7:4] == TAG_LEAD3) begin
        lead_need = 2'd2;
      end else if (in_byte[7:3] == TAG_LEAD4) begin
        lead_need = 2'd3;
      end else begin
        esc_now = 1'b1;
      end
      if (esc_now || raw_now) begin
        p = put(p, esc_now, in_byte);
      end else begin
        held_next[0]    = in_byte;
        held_count_next = 2'd1;
        need_next       = lead_need;
      end
    end

    // string ends while holding
    if (in_last && held_count_next != 2'd0) begin
      for (int i = 0; i < HELD_DEPTH; i++) begin
        if (2'(i) < held_count_next) p = put(p, 1'b1, held_next[i]);
      end
      held_count_next = 2'd0;
      need_next       = 2'd0;
    end

    plan = p;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      need       <= 2'd0;
    end else if (take) begin
      held_count <= held_count_next;
      need       <= need_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/jeu_emit.sv =====
`default_nettype none

module jeu_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  jeu_pkg::plan_t  plan,
  output logic            busy,
  jeu_out_if.source       escaped
);
  import jeu_pkg::*;

  state_t                state;
  state_t                state_next;
  unit_t [MAX_UNITS-1:0] units;
  logic  [2:0]           count;
  logic                  str_last;
  logic  [1:0]           uidx;
  logic  [2:0]           cidx;

  unit_t cur;
  logic  unit_done;
  logic  final_unit;
  logic  final_char;
  byte_t ch;

  always_comb begin
    cur        = units[uidx];
    unit_done  = !cur.esc || (cidx == POS_LO);
    final_unit = ({1'b0, uidx} + 3'd1) == count;
    final_char = unit_done && final_unit;
    ch         = cur.value;
    if (cur.esc) begin
      unique case (cidx)
        POS_BSLASH: ch = CH_BSLASH;
        POS_U:      ch = CH_U;
        POS_ZERO0:  ch = CH_ZERO;
        POS_ZERO1:  ch = CH_ZERO;
        POS_HI:     ch = hex_digit(cur.value[7:4]);
        POS_LO:     ch = hex_digit(cur.value[3:0]);
        default:    ch = CH_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next          = state;
    busy                = 1'b0;
    escaped.valid       = 1'b0;
    escaped.out_byte    = ch;
    escaped.run_last    = final_char;
    escaped.string_end  = final_char && str_last;
    unique case (state)
      ST_IDLE: begin
        if (take && plan.count != 3'd0) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        busy          = 1'b1;
        escaped.valid = 1'b1;
        if (escaped.ready && final_char) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      units    <= plan.units;
      count    <= plan.count;
      str_last <= plan.last;
      uidx     <= 2'd0;
      cidx     <= 3'd0;
    end else if (state == ST_EMIT && escaped.ready) begin
      if (unit_done) begin
        uidx <= uidx + 2'd1;
        cidx <= 3'd0;
      end else begin
        cidx <= cidx + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/json_escape_utf8_validate_core.sv =====
// json string escaper with utf-8 validation
//
// raw: one input byte per transfer, in_last flags the final byte of a string.
// escaped: output bytes, run_last flags the last byte caused by an input byte,
// string_end flags the final output byte of the whole string.
//
// an input byte is taken when raw.valid and raw.ready are both high; its results
// then leave one byte per cycle while escaped.ready is high, from a registered
// plan of up to four units (plain or six-char escape), 0 to 24 output bytes per
// input byte. raw.ready is low while a plan is being sent; a byte that only
// extends a held utf-8 sequence sends nothing and leaves raw.ready high.
//
// a stall on escaped holds the current byte and its flags; nothing is lost.
// reset clears the held-sequence count and the sequencer; held bytes need no
// clearing. no results are pending after reset.
`default_nettype none

module json_escape_utf8_validate_core (
  input logic       clk,
  input logic       rst,
  jeu_in_if.sink    raw,
  jeu_out_if.source escaped
);
  import jeu_pkg::*;

  logic  busy;
  logic  take;
  plan_t plan;

  assign raw.ready = !busy;
  assign take      = raw.valid && raw.ready;

  jeu_plan u_plan (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (raw.in_byte),
    .in_last (raw.in_last),
    .plan    (plan)
  );

  jeu_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .plan    (plan),
    .busy    (busy),
    .escaped (escaped)
  );

  a_no_take_while_sending: assert property (@(posedge clk) disable iff (rst)
    escaped.valid |-> !raw.ready)
    else $error("input taken while results pending");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    escaped.valid && escaped.ready && !escaped.run_last |=> escaped.valid)
    else $error("run ended without run_last");

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    escaped.valid && escaped.string_end |-> escaped.run_last)
    else $error("string_end outside run end");

  a_empty_plan_idle: assert property (@(posedge clk) disable iff (rst)
    take && plan.count == 3'd0 |=> !escaped.valid)
    else $error("output from empty plan");

endmodule

`default_nettype wire

// ===== bench/json_escape_utf8_validate_core_tb.sv =====
`timescale 1ns / 100ps

module json_escape_utf8_validate_core_tb;
  import jeu_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 255;
  localparam int MAX_WAIT     = 13;
  localparam int DIRECTED_N   = 25;

  // {in_last, in_byte}
  localparam logic [8:0] DIRECTED [DIRECTED_N] = '{
    9'h000, 9'h01F, 9'h022, 9'h05C, 9'h07F, 9'h141,
    9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC, 9'h0F0, 9'h09F, 9'h098, 9'h180,
    9'h080, 9'h0F8, 9'h0FF,
    9'h0E2, 9'h041,
    9'h0F0, 9'h090, 9'h090, 9'h05C,
    9'h1C3
  };

  typedef struct packed {
    byte_t ch;
    logic  run_last;
    logic  string_end;
  } esc_char_t;

  class escape_checker;
    esc_char_t expected_chars[$];
    esc_char_t run[$];
    byte_t     held[HELD_DEPTH];
    int        held_n;
    int        need;
    int        mismatches;
    string     hex_set;

    function new();
      held_n     = 0;
      need       = 0;
      mismatches = 0;
      hex_set    = "0123456789ABCDEF";
    endfunction

    function void put_plain(byte_t b);
      esc_char_t c;
      c.ch         = b;
      c.run_last   = 1'b0;
      c.string_end = 1'b0;
      run.push_back(c);
    endfunction

    function void put_escape(byte_t b);
      put_plain(CH_BSLASH);
      put_plain(CH_U);
      put_plain(CH_ZERO);
      put_plain(CH_ZERO);
      put_plain(byte_t'(hex_set[b[7:4]]));
      put_plain(byte_t'(hex_set[b[3:0]]));
    endfunction

    function void flush_held();
      for (int i = 0; i < held_n; i++) put_escape(held[i]);
      held_n = 0;
      need   = 0;
    endfunction

    function void expand_fresh(byte_t b);
      int n;
      n = 0;
      if (b < CTRL_LIMIT || b == CH_BSLASH || b == CH_QUOTE) begin
        put_escape(b);
      end else if (!b[7]) begin
        put_plain(b);
      end else if (b[7:6] == TAG_CONT) begin
        put_escape(b);
      end else if (b[7:5] == TAG_LEAD2) begin
        n = 1;
      end else if (b[7:4] == TAG_LEAD3) begin
        n = 2;
      end else if (b[7:3] == TAG_LEAD4) begin
        n = 3;
      end else begin
        put_escape(b);
      end
      if (n != 0) begin
        held[0] = b;
        held_n  = 1;
        need    = n;
      end
    endfunction

    // work out the output bytes caused by one accepted input byte
    function void note_raw(byte_t b, logic last);
      run.delete();
      if (held_n != 0) begin
        if (b[7:6] == TAG_CONT) begin
          if (need <= 1) begin
            for (int i = 0; i < held_n; i++) put_plain(held[i]);
            put_plain(b);
            held_n = 0;
            need   = 0;
          end else if (held_n < HELD_DEPTH) begin
            held[held_n] = b;
            held_n++;
            need--;
          end else begin
            flush_held();
            put_escape(b);
          end
        end else begin
          flush_held();
          expand_fresh(b);
        end
      end else begin
        expand_fresh(b);
      end
      if (last && held_n != 0) flush_held();
      if (run.size() > 0) begin
        run[run.size()-1].run_last = 1'b1;
        if (last) run[run.size()-1].string_end = 1'b1;
      end
      foreach (run[i]) expected_chars.push_back(run[i]);
    endfunction

    function void check_char(byte_t b, logic rl, logic se);
      esc_char_t e;
      if (expected_chars.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected output: byte %02h run_last %0b string_end %0b", b, rl, se);
        mismatches++;
        return;
      end
      e = expected_chars.pop_front();
      if (e.ch !== b || e.run_last !== rl || e.string_end !== se) begin
        if (mismatches < 10)
          $display("mismatch: expected byte %02h run_last %0b string_end %0b, got %02h %0b %0b",
                   e.ch, e.run_last, e.string_end, b, rl, se);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   in_burst;
  bit   out_burst;
  int   idle_cycles;

  jeu_in_if  raw_if ();
  jeu_out_if esc_if ();

  escape_checker chk = new();

  json_escape_utf8_validate_core dut (
    .clk     (clk),
    .rst     (rst),
    .raw     (raw_if),
    .escaped (esc_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // gap before the next transfer, with runs of back-to-back transfers
  function int draw_wait(inout bit burst);
    if ($urandom_range(0, 29) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function byte_t lead_byte(int len);
    byte_t b;
    b = byte_t'($urandom_range(0, 255));
    case (len)
      2: b[7:5] = TAG_LEAD2;
      3: b[7:4] = TAG_LEAD3;
      default: b[7:3] = TAG_LEAD4;
    endcase
    return b;
  endfunction

  function byte_t cont_byte();
    byte_t b;
    b = byte_t'($urandom_range(0, 255));
    b[7:6] = TAG_CONT;
    return b;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_raw(input byte_t b, input logic last);
    int gap;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      raw_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    raw_if.valid   = 1'b1;
    raw_if.in_byte = b;
    raw_if.in_last = last;
    do @(posedge clk); while (!raw_if.ready);
    chk.note_raw(b, last);
    @(negedge clk);
  endtask

  task automatic send_segment(inout int sent);
    byte_t seq[$];
    int    kind;
    int    len;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      len = $urandom_range(1, 4);
      repeat (len) seq.push_back(byte_t'($urandom_range(8'h20, 8'h7E)));
    end else if (kind < 35) begin
      case ($urandom_range(0, 3))
        0: seq.push_back(CH_BSLASH);
        1: seq.push_back(CH_QUOTE);
        2: seq.push_back(8'h7F);
        default: seq.push_back(byte_t'($urandom_range(0, 8'h1F)));
      endcase
    end else if (kind < 70) begin
      len = $urandom_range(2, 4);
      seq.push_back(lead_byte(len));
      repeat (len - 1) seq.push_back(cont_byte());
    end else if (kind < 80) begin
      // sequence cut short by a non-continuation byte
      len = $urandom_range(2, 4);
      seq.push_back(lead_byte(len));
      repeat ($urandom_range(0, len - 2)) seq.push_back(cont_byte());
      if ($urandom_range(0, 1) == 0) seq.push_back(byte_t'($urandom_range(0, 8'h7F)));
      else seq.push_back(byte_t'($urandom_range(8'hC0, 8'hFF)));
    end else if (kind < 88) begin
      seq.push_back(cont_byte());
    end else if (kind < 94) begin
      seq.push_back(byte_t'($urandom_range(8'hF8, 8'hFF)));
    end else begin
      seq.push_back(byte_t'($urandom_range(0, 255)));
    end
    foreach (seq[i]) send_raw(seq[i], $urandom_range(0, 11) == 0);
    sent += seq.size();
  endtask

  initial begin
    int sent;
    rst            = 1'b1;
    raw_if.valid   = 1'b0;
    raw_if.in_byte = 8'h00;
    raw_if.in_last = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    for (int i = 0; i < DIRECTED_N; i++) send_raw(DIRECTED[i][7:0], DIRECTED[i][8]);
    sent = 0;
    while (sent < RANDOM_ITEMS) send_segment(sent);
    raw_if.valid = 1'b0;
    while (chk.expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.mismatches == 0 && chk.expected_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // output side: random stalls before each transfer
  initial begin
    int stall;
    esc_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait(out_burst);
      if (stall > 0) begin
        esc_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      esc_if.ready = 1'b1;
      do @(posedge clk); while (!esc_if.valid);
      chk.check_char(esc_if.out_byte, esc_if.run_last, esc_if.string_end);
      @(negedge clk);
    end
  end

  initial idle_cycles = 0;

  always @(posedge clk) begin
    if ((raw_if.valid && raw_if.ready) || (esc_if.valid && esc_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
src/jeu_pkg.sv
src/jeu_if.sv
src/jeu_plan.sv
src/jeu_emit.sv
src/json_escape_utf8_validate_core.sv
bench/json_escape_utf8_validate_core_tb.sv
